/* hw/rtl/cmsp_pkg.sv */
package cmsp_pkg;

    // Protocol constants.
    localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;
    localparam logic [3:0]  NIB_EXT8       = 4'd13;
    localparam logic [3:0]  NIB_EXT16      = 4'd14;
    localparam logic [3:0]  MAX_TOKEN_LEN  = 4'd8;
    localparam logic [15:0] EXT8_BASE      = 16'd13;
    localparam logic [15:0] EXT16_BASE     = 16'd269;

    typedef enum logic [11:0] {
        PH_HEADER  = 12'b0000_0000_0001,
        PH_TOKEN   = 12'b0000_0000_0010,
        PH_OPTHDR  = 12'b0000_0000_0100,
        PH_DX1     = 12'b0000_0000_1000,
        PH_DX2H    = 12'b0000_0001_0000,
        PH_DX2L    = 12'b0000_0010_0000,
        PH_LX1     = 12'b0000_0100_0000,
        PH_LX2H    = 12'b0000_1000_0000,
        PH_LX2L    = 12'b0001_0000_0000,
        PH_VALUE   = 12'b0010_0000_0000,
        PH_PAYLOAD = 12'b0100_0000_0000,
        PH_SKIP    = 12'b1000_0000_0000
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_HEADER     = 3'd1,
        EV_TOKEN      = 3'd2,
        EV_OPT_HEADER = 3'd3,
        EV_OPT_VALUE  = 3'd4,
        EV_PAYLOAD    = 3'd5,
        EV_MARKER     = 3'd6
    } event_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SHORT     = 2'd1,
        ST_BAD_TOKEN = 2'd2,
        ST_TRUNCATED = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [1:0]  version;
        logic [1:0]  msg_type;
        logic [3:0]  token_length;
        logic [7:0]  code;
        logic [15:0] msg_ident;
        logic [15:0] option_number;
        logic [15:0] option_length;
        logic [7:0]  data_value;
        logic        message_end;
        logic [1:0]  status;
    } out_item_t;

    // Parser context carried from one byte to the next.
    typedef struct packed {
        phase_t      phase;
        logic [1:0]  hdr_pos;
        logic [1:0]  version;
        logic [1:0]  msg_type;
        logic [3:0]  tok_count;
        logic [7:0]  code;
        logic [15:0] msg_ident;
        logic [3:0]  token_rem;
        logic [15:0] run_number;
        logic [15:0] pend_delta;
        logic [15:0] pend_length;
        logic [7:0]  ext_high;
        logic [15:0] value_rem;
    } parse_state_t;

    function automatic parse_state_t reset_state();
        parse_state_t s;
        s       = '0;
        s.phase = PH_HEADER;
        return s;
    endfunction

endpackage

/* hw/rtl/coap_message_stream_parser.sv */
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+------------------------------------------
// in       | input     | in_valid/in_ready  | in_data  : data_byte, last_byte
// out      | output    | out_valid/out_ready| out_data : event, header, option, status
//
// Every accepted byte yields exactly one result transaction, presented in the cycle after acceptance.
// A byte can be accepted every cycle while the output is not stalled; throughput is one
// byte per cycle, set by the combinational parse step feeding one output register.
// Reset (rst_n low, asynchronous) clears the parse context to the header phase and
// empties the output register.
// When out_ready is low with a result held, in_ready drops and the parser context holds.

module coap_message_stream_parser
    import cmsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    // The parse context is the per-message state: header fields captured so far,
    // the token and option value down-counters, the running option number and the
    // pending option delta and length.
    parse_state_t state_reg;
    parse_state_t state_next;
    out_item_t    step_result;
    logic         in_accept;

    // One byte moves the parser through one step of the message layout: header
    // bytes, token bytes, option headers with their extension bytes, option
    // values, the payload marker and payload bytes.
    cmsp_decode u_decode (
        .cur    (state_reg),
        .item   (in_data),
        .nxt    (state_next),
        .result (step_result)
    );

    // The output register decouples the two sides, so a new byte is taken in the
    // same cycle that the previous result leaves.
    cmsp_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (in_valid),
        .load_ready (in_ready),
        .load_data  (step_result),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    assign in_accept = in_valid && in_ready;

    // The context advances only when a byte transaction completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= reset_state();
        end
        else if (in_accept)
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/cmsp_decode.sv */
module cmsp_decode
    import cmsp_pkg::*;
(
    input  parse_state_t cur,
    input  in_item_t     item,
    output parse_state_t nxt,
    output out_item_t    result
);

    parse_state_t upd;
    event_t       ev;
    logic [7:0]   dv;
    logic         do_after;
    logic         do_finish;
    status_t      st;
    logic         hdr_seen;
    logic         opt_event;
    logic [7:0]   b;

    assign b = item.data_byte;

    always_comb
    begin
        upd       = cur;
        ev        = EV_NONE;
        dv        = '0;
        do_after  = 1'b0;
        do_finish = 1'b0;

        case (cur.phase)
            PH_HEADER:
            begin
                case (cur.hdr_pos)
                    2'd0:
                    begin
                        upd.version   = b[7:6];
                        upd.msg_type  = b[5:4];
                        upd.tok_count = b[3:0];
                    end
                    2'd1:    upd.code = b;
                    2'd2:    upd.msg_ident = {b, 8'h00};
                    default:
                    begin
                        upd.msg_ident = {cur.msg_ident[15:8], b};
                        ev            = EV_HEADER;
                        if (cur.tok_count > MAX_TOKEN_LEN)
                        begin
                            upd.phase = PH_SKIP;
                        end
                        else if (cur.tok_count != 4'd0)
                        begin
                            upd.token_rem = cur.tok_count;
                            upd.phase     = PH_TOKEN;
                        end
                        else
                        begin
                            upd.phase = PH_OPTHDR;
                        end
                    end
                endcase
                upd.hdr_pos = cur.hdr_pos + 2'd1;
            end
            PH_TOKEN:
            begin
                ev            = EV_TOKEN;
                dv            = b;
                upd.token_rem = cur.token_rem - 4'd1;
                if (upd.token_rem == 4'd0)
                begin
                    upd.phase = PH_OPTHDR;
                end
            end
            PH_OPTHDR:
            begin
                if (b == PAYLOAD_MARKER)
                begin
                    ev        = EV_MARKER;
                    upd.phase = PH_PAYLOAD;
                end
                else
                begin
                    upd.pend_length = {12'h000, b[3:0]};
                    upd.pend_delta  = {12'h000, b[7:4]};
                    if (b[7:4] == NIB_EXT8)
                    begin
                        upd.phase = PH_DX1;
                    end
                    else if (b[7:4] == NIB_EXT16)
                    begin
                        upd.phase = PH_DX2H;
                    end
                    else
                    begin
                        do_after = 1'b1;
                    end
                end
            end
            PH_DX1:
            begin
                upd.pend_delta = {8'h00, b} + EXT8_BASE;
                do_after       = 1'b1;
            end
            PH_DX2H:
            begin
                upd.ext_high = b;
                upd.phase    = PH_DX2L;
            end
            PH_DX2L:
            begin
                upd.pend_delta = {cur.ext_high, b} + EXT16_BASE;
                do_after       = 1'b1;
            end
            PH_LX1:
            begin
                upd.pend_length = {8'h00, b} + EXT8_BASE;
                do_finish       = 1'b1;
            end
            PH_LX2H:
            begin
                upd.ext_high = b;
                upd.phase    = PH_LX2L;
            end
            PH_LX2L:
            begin
                upd.pend_length = {cur.ext_high, b} + EXT16_BASE;
                do_finish       = 1'b1;
            end
            PH_VALUE:
            begin
                ev            = EV_OPT_VALUE;
                dv            = b;
                upd.value_rem = cur.value_rem - 16'd1;
                if (upd.value_rem == 16'd0)
                begin
                    upd.phase = PH_OPTHDR;
                end
            end
            PH_PAYLOAD:
            begin
                ev = EV_PAYLOAD;
                dv = b;
            end
            default:
            begin
            end
        endcase

        // The length nibble may still call for extension bytes once the delta is known.
        if (do_after)
        begin
            if (upd.pend_length == {12'h000, NIB_EXT8})
            begin
                upd.phase = PH_LX1;
            end
            else if (upd.pend_length == {12'h000, NIB_EXT16})
            begin
                upd.phase = PH_LX2H;
            end
            else
            begin
                do_finish = 1'b1;
            end
        end

        if (do_finish)
        begin
            upd.run_number = cur.run_number + upd.pend_delta;
            upd.value_rem  = upd.pend_length;
            upd.phase      = (upd.pend_length != 16'd0) ? PH_VALUE : PH_OPTHDR;
            ev             = EV_OPT_HEADER;
        end
    end

    // Status is judged on the phase reached after this byte.
    always_comb
    begin
        case (upd.phase)
            PH_SKIP,
            PH_TOKEN:   st = ST_BAD_TOKEN;
            PH_HEADER:  st = ST_SHORT;
            PH_DX1,
            PH_DX2H,
            PH_DX2L,
            PH_LX1,
            PH_LX2H,
            PH_LX2L,
            PH_VALUE:   st = ST_TRUNCATED;
            default:    st = ST_OK;
        endcase
    end

    assign hdr_seen  = (upd.phase != PH_HEADER);
    assign opt_event = (ev == EV_OPT_HEADER) || (ev == EV_OPT_VALUE);

    always_comb
    begin
        result.event_kind    = ev;
        result.version       = hdr_seen ? upd.version : 2'd0;
        result.msg_type      = hdr_seen ? upd.msg_type : 2'd0;
        result.token_length  = hdr_seen ? upd.tok_count : 4'd0;
        result.code          = hdr_seen ? upd.code : 8'd0;
        result.msg_ident     = hdr_seen ? upd.msg_ident : 16'd0;
        result.option_number = opt_event ? upd.run_number : 16'd0;
        result.option_length = opt_event ? upd.pend_length : 16'd0;
        result.data_value    = dv;
        result.message_end   = item.last_byte;
        result.status        = item.last_byte ? st : ST_OK;
    end

    // The final byte of a message returns the context to its reset value.
    assign nxt = item.last_byte ? reset_state() : upd;

endmodule

/* hw/rtl/cmsp_out_stage.sv */
module cmsp_out_stage
    import cmsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load_valid,
    output logic      load_ready,
    input  out_item_t load_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;

    // The register can take a new result whenever it is empty or being drained.
    assign load_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load_ready)
        begin
            valid_next = load_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
